>>> hw/rtl/odrh_pkg.sv
// Shared types, constants and helper functions for the ordered dither
// and RGB histogram block. No dependencies.
`default_nettype none

package odrh_pkg;

	// Histogram geometry.
	localparam int BIN_COUNT   = 256;
	localparam int BIN_W       = $clog2(BIN_COUNT);
	localparam int COUNT_WIDTH = 32;
	localparam int CNT_OUT_W   = 32;

	// Pixel and coordinate widths.
	localparam int CHAN_W  = 8;
	localparam int COORD_W = 12;
	localparam int THR_W   = 4;

	// Queue depths between the parts of the block.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DEPTH   = 4;
	localparam int OPTR_W      = $clog2(OUT_DEPTH);
	localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

	localparam logic [CHAN_W-1:0]      FULL_LEVEL = {CHAN_W{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX    = {COUNT_WIDTH{1'b1}};

	typedef logic [BIN_W-1:0]       bin_t;
	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	// Action codes carried by an input word.
	typedef enum logic {
		ACT_PIXEL = 1'b0,
		ACT_READ  = 1'b1
	} action_t;

	// Input word as it arrives on the input queue port.
	typedef struct packed {
		action_t             action;
		logic [COORD_W-1:0]  column;
		logic [COORD_W-1:0]  row;
		logic [CHAN_W-1:0]   red_in;
		logic [CHAN_W-1:0]   green_in;
		logic [CHAN_W-1:0]   blue_in;
		logic [BIN_W-1:0]    bin_index;
	} item_t;

	// Result word as it leaves on the output queue port.
	typedef struct packed {
		logic [CHAN_W-1:0]    red_out;
		logic [CHAN_W-1:0]    green_out;
		logic [CHAN_W-1:0]    blue_out;
		logic [CNT_OUT_W-1:0] red_count;
		logic [CNT_OUT_W-1:0] green_count;
		logic [CNT_OUT_W-1:0] blue_count;
	} result_t;

	// Classified word passed from the front part to the back part.
	typedef struct packed {
		action_t action;
		logic    red_hi;
		logic    green_hi;
		logic    blue_hi;
		bin_t    red_addr;
		bin_t    green_addr;
		bin_t    blue_addr;
	} work_t;

	// Write request into one histogram bank.
	typedef struct packed {
		logic en;
		bin_t addr;
		cnt_t data;
	} bank_wr_t;

	// 4x4 Bayer matrix, row-major, indexed by {row[1:0], column[1:0]}.
	localparam logic [THR_W-1:0] BAYER [16] = '{
		4'd0,  4'd8,  4'd2,  4'd10,
		4'd12, 4'd4,  4'd14, 4'd6,
		4'd3,  4'd11, 4'd1,  4'd9,
		4'd15, 4'd7,  4'd13, 4'd5
	};

	function automatic logic [THR_W-1:0] bayer_thr(input logic [1:0] r, input logic [1:0] c);
		return BAYER[{r, c}];
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/odrh_front.sv
// Front part: accepts input words, looks up the dither threshold and
// forms the bin addresses. Depends on odrh_pkg.
`default_nettype none

module odrh_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire odrh_pkg::item_t item,
	output logic                q_push,
	output odrh_pkg::work_t     q_data,
	input  wire logic           q_can_push
);
	import odrh_pkg::*;

	logic                  vld_s1;
	work_t                 work_s1;
	work_t                 work_d;
	logic [THR_W-1:0]      thr;
	logic [CHAN_W-1:0]     thr_level;
	logic                  take;
	logic                  is_pix;

	// Threshold from the low coordinate bits, scaled by sixteen.
	always_comb begin
		thr       = bayer_thr(item.row[1:0], item.column[1:0]);
		thr_level = {thr, 4'b0000};
		is_pix    = (item.action == ACT_PIXEL);
		work_d.action     = item.action;
		work_d.red_hi     = is_pix && (item.red_in > thr_level);
		work_d.green_hi   = is_pix && (item.green_in > thr_level);
		work_d.blue_hi    = is_pix && (item.blue_in > thr_level);
		work_d.red_addr   = is_pix ? item.red_in : item.bin_index;
		work_d.green_addr = is_pix ? item.green_in : item.bin_index;
		work_d.blue_addr  = is_pix ? item.blue_in : item.bin_index;
	end

	// The stage register drains into the queue whenever the queue has room.
	assign q_push = vld_s1 && q_can_push;
	assign q_data = work_s1;
	assign full   = vld_s1 && !q_can_push;
	assign take   = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			work_s1 <= work_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/odrh_queue.sv
// Short queue of classified words between the front and back parts.
// Depends on odrh_pkg.
`default_nettype none

module odrh_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire odrh_pkg::work_t wr_data,
	output logic                 can_push,
	input  wire logic            rd_en,
	output odrh_pkg::work_t      rd_data,
	output logic                 nonempty
);
	import odrh_pkg::*;

	work_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign can_push = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign do_wr    = wr_en && can_push;
	assign do_rd    = rd_en && nonempty;
	assign rd_data  = slot_q[rd_ptr_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/odrh_bank.sv
// One histogram bank: bin memory with registered read, per-bin valid bits
// cleared at reset, and forwarding of the previous write. Depends on odrh_pkg.
`default_nettype none

module odrh_bank (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire odrh_pkg::bin_t     rd_addr,
	input  wire odrh_pkg::bank_wr_t wr,
	output odrh_pkg::cnt_t          count
);
	import odrh_pkg::*;

	cnt_t                 mem [BIN_COUNT];
	logic [BIN_COUNT-1:0] valid_q;
	cnt_t                 rd_data_q;
	logic                 rd_vld_q;
	logic                 fwd_q;
	cnt_t                 fwd_data_q;

	// Memory port: one read and one write per cycle, read data registered.
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		fwd_data_q <= wr.data;
	end

	// Valid bits make an unwritten bin read as zero after reset. A write at
	// the same edge as the read is not yet in memory, so it is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[rd_addr];
			fwd_q    <= wr.en && (wr.addr == rd_addr);
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
		end
	end

	assign count = fwd_q ? fwd_data_q : (rd_vld_q ? rd_data_q : '0);

endmodule

`default_nettype wire

>>> hw/rtl/odrh_back.sv
// Back part: histogram read-modify-write over three banks and the result
// queue. Depends on odrh_pkg and odrh_bank.
`default_nettype none

module odrh_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_nonempty,
	input  wire odrh_pkg::work_t q_data,
	output logic                 q_pop,
	output logic                 empty,
	input  wire logic            pop,
	output odrh_pkg::result_t    result
);
	import odrh_pkg::*;

	logic              vld_s1;
	work_t             work_s1;
	cnt_t              red_old;
	cnt_t              green_old;
	cnt_t              blue_old;
	cnt_t              red_new;
	cnt_t              green_new;
	cnt_t              blue_new;
	bank_wr_t          red_wr;
	bank_wr_t          green_wr;
	bank_wr_t          blue_wr;
	logic              do_wr;
	result_t           res_d;
	result_t           res_q [OUT_DEPTH];
	logic [OPTR_W-1:0] owr_ptr_q;
	logic [OPTR_W-1:0] ord_ptr_q;
	logic [OCNT_W-1:0] ocnt_q;
	logic              out_push;
	logic              out_pop;

	// Take a word only when the result queue has room for it and the one
	// already in flight.
	assign q_pop = q_nonempty &&
		((ocnt_q + OCNT_W'(vld_s1)) < OCNT_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_s1 <= q_data;
		end
	end

	// Bin reads are issued from the queue head; counts return with the word.
	odrh_bank u_red (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (q_data.red_addr),
		.wr      (red_wr),
		.count   (red_old)
	);

	odrh_bank u_green (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (q_data.green_addr),
		.wr      (green_wr),
		.count   (green_old)
	);

	odrh_bank u_blue (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (q_data.blue_addr),
		.wr      (blue_wr),
		.count   (blue_old)
	);

	// Saturating increment and write-back for pixel words.
	always_comb begin
		red_new   = (red_old == CNT_MAX) ? red_old : red_old + 1'b1;
		green_new = (green_old == CNT_MAX) ? green_old : green_old + 1'b1;
		blue_new  = (blue_old == CNT_MAX) ? blue_old : blue_old + 1'b1;
		do_wr     = vld_s1 && (work_s1.action == ACT_PIXEL);

		red_wr.en     = do_wr;
		red_wr.addr   = work_s1.red_addr;
		red_wr.data   = red_new;
		green_wr.en   = do_wr;
		green_wr.addr = work_s1.green_addr;
		green_wr.data = green_new;
		blue_wr.en    = do_wr;
		blue_wr.addr  = work_s1.blue_addr;
		blue_wr.data  = blue_new;
	end

	// Result word: dithered levels and counts, the full width of each bin.
	always_comb begin
		res_d.red_out   = work_s1.red_hi ? FULL_LEVEL : '0;
		res_d.green_out = work_s1.green_hi ? FULL_LEVEL : '0;
		res_d.blue_out  = work_s1.blue_hi ? FULL_LEVEL : '0;
		if (work_s1.action == ACT_PIXEL) begin
			res_d.red_count   = CNT_OUT_W'(red_new);
			res_d.green_count = CNT_OUT_W'(green_new);
			res_d.blue_count  = CNT_OUT_W'(blue_new);
		end else begin
			res_d.red_count   = CNT_OUT_W'(red_old);
			res_d.green_count = CNT_OUT_W'(green_old);
			res_d.blue_count  = CNT_OUT_W'(blue_old);
		end
	end

	// Result queue toward the consumer.
	assign out_push = vld_s1;
	assign empty    = (ocnt_q == '0);
	assign out_pop  = pop && !empty;
	assign result   = res_q[ord_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= '0;
			ord_ptr_q <= '0;
			ocnt_q    <= '0;
		end else begin
			if (out_push) begin
				owr_ptr_q <= owr_ptr_q + 1'b1;
			end
			if (out_pop) begin
				ord_ptr_q <= ord_ptr_q + 1'b1;
			end
			if (out_push && !out_pop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (out_pop && !out_push) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			res_q[owr_ptr_q] <= res_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ordered_dither_rgb_histogram_top.sv
// Top level of the ordered dither and RGB histogram block.
// Depends on odrh_pkg, odrh_front, odrh_queue and odrh_back.
//
// Usage:
//   Input words enter on item with push/full; a word is taken at a clock
//   edge where push is high and full is low. A pixel word (action pixel)
//   is dithered with the 4x4 Bayer matrix and bumps one bin in each of the
//   red, green and blue histograms; a read word returns the three counts
//   of bin_index and changes nothing.
//   Each input word gives exactly one result word on result, shown while
//   empty is low and taken at an edge where pop is high.
//   Words pass front register, internal queue, back register and result queue.
//   Throughput is one word per cycle while the consumer keeps popping: each
//   histogram bank does one read and one write per cycle, and a back-to-back
//   update of the same bin is forwarded from the write of the previous cycle.
//   If the consumer stops popping, the result queue (4 words) and the
//   internal queue (4 words) fill, and then full rises; nothing is lost.
//   Reset clears all control state and every bin reads as zero right after
//   reset, through per-bin valid bits; no clearing pass is needed.
`default_nettype none

module ordered_dither_rgb_histogram_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire odrh_pkg::item_t  item,
	output logic                  empty,
	input  wire logic             pop,
	output odrh_pkg::result_t     result
);
	import odrh_pkg::*;

	logic  fq_push;
	work_t fq_data;
	logic  fq_can_push;
	logic  bq_pop;
	work_t bq_data;
	logic  bq_nonempty;

	// Accept and classify.
	odrh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.q_push     (fq_push),
		.q_data     (fq_data),
		.q_can_push (fq_can_push)
	);

	// Decoupling queue.
	odrh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fq_push),
		.wr_data  (fq_data),
		.can_push (fq_can_push),
		.rd_en    (bq_pop),
		.rd_data  (bq_data),
		.nonempty (bq_nonempty)
	);

	// Histogram update and result queue.
	odrh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (bq_nonempty),
		.q_data     (bq_data),
		.q_pop      (bq_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for ordered_dither_rgb_histogram_top: directed and random words
// checked against typed expected words or an in-bench dither and histogram predictor.
// Depends on odrh_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module testbench;
	import odrh_pkg::*;

	// One row of the directed table; typed rows carry their expected word.
	typedef struct {
		item_t   word;
		bit      typed;
		result_t want;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 20;
	localparam int RANDOM_WORDS  = 530;

	// Bayer thresholds, indexed [row & 3][column & 3].
	localparam logic [3:0] DITHER_THRESH [4][4] = '{
		'{4'd0,  4'd8,  4'd2,  4'd10},
		'{4'd12, 4'd4,  4'd14, 4'd6},
		'{4'd3,  4'd11, 4'd1,  4'd9},
		'{4'd15, 4'd7,  4'd13, 4'd5}
	};

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	result_t result;

	// Predictor state: one shadow histogram per channel.
	cnt_t red_bins   [256];
	cnt_t green_bins [256];
	cnt_t blue_bins  [256];

	result_t   pending_results [$];
	result_t   oldest_expected;
	stim_row_t directed [DIRECTED_ROWS];
	logic [7:0] hot_values [8];
	int        fail_count   = 0;
	int        results_seen = 0;
	int        words_sent   = 0;
	int        burst_left   = 0;

	ordered_dither_rgb_histogram_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Build a pixel word.
	function automatic item_t pixel_word(input logic [11:0] col, input logic [11:0] rw,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [7:0] bin);
		item_t w;
		w.action    = ACT_PIXEL;
		w.column    = col;
		w.row       = rw;
		w.red_in    = r;
		w.green_in  = g;
		w.blue_in   = b;
		w.bin_index = bin;
		return w;
	endfunction

	// Build a read word; the ignored fields are all zeros or all ones.
	function automatic item_t read_word(input logic [7:0] bin, input bit fill);
		item_t w;
		w           = fill ? '1 : '0;
		w.action    = ACT_READ;
		w.bin_index = bin;
		return w;
	endfunction

	// Result word with the same level on all channels and the same count in all bins.
	function automatic result_t uniform_result(input logic [7:0] lvl, input cnt_t cnt);
		result_t r;
		r.red_out     = lvl;
		r.green_out   = lvl;
		r.blue_out    = lvl;
		r.red_count   = cnt;
		r.green_count = cnt;
		r.blue_count  = cnt;
		return r;
	endfunction

	// Dither one pixel or read one bin, updating the shadow histograms.
	task automatic dither_and_bin(input item_t w, output result_t r);
		logic [3:0] thr;
		thr = DITHER_THRESH[w.row[1:0]][w.column[1:0]];
		if (w.action == ACT_READ) begin
			r             = '0;
			r.red_count   = red_bins[w.bin_index];
			r.green_count = green_bins[w.bin_index];
			r.blue_count  = blue_bins[w.bin_index];
		end else begin
			r.red_out   = (w.red_in > {thr, 4'b0000}) ? FULL_LEVEL : 8'h00;
			r.green_out = (w.green_in > {thr, 4'b0000}) ? FULL_LEVEL : 8'h00;
			r.blue_out  = (w.blue_in > {thr, 4'b0000}) ? FULL_LEVEL : 8'h00;
			// Counts stick at the top of their range.
			if (red_bins[w.red_in] != CNT_MAX)
				red_bins[w.red_in] += 1;
			if (green_bins[w.green_in] != CNT_MAX)
				green_bins[w.green_in] += 1;
			if (blue_bins[w.blue_in] != CNT_MAX)
				blue_bins[w.blue_in] += 1;
			r.red_count   = red_bins[w.red_in];
			r.green_count = green_bins[w.green_in];
			r.blue_count  = blue_bins[w.blue_in];
		end
	endtask

	// Channel values lean toward hot bins and threshold edges.
	function automatic logic [7:0] pick_channel(input logic [3:0] thr);
		int k;
		int v;
		k = $urandom_range(0, 9);
		if (k < 4)
			return hot_values[$urandom_range(0, 7)];
		if (k < 7) begin
			v = 16 * thr + $urandom_range(0, 2) - 1;
			return (v < 0) ? 8'd0 : v[7:0];
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Random word: mostly pixels, some reads, now and then a repeat of the last one.
	task automatic make_random_word(inout item_t last, output item_t w);
		logic [3:0] thr;
		if ($urandom_range(0, 9) == 0) begin
			w = last;
		end else begin
			w.action    = ($urandom_range(0, 4) == 0) ? ACT_READ : ACT_PIXEL;
			w.column    = 12'($urandom_range(0, 4095));
			w.row       = 12'($urandom_range(0, 4095));
			w.bin_index = $urandom_range(0, 1) ? hot_values[$urandom_range(0, 7)]
				: 8'($urandom_range(0, 255));
			thr         = DITHER_THRESH[w.row[1:0]][w.column[1:0]];
			w.red_in    = pick_channel(thr);
			w.green_in  = pick_channel(thr);
			w.blue_in   = pick_channel(thr);
		end
		last = w;
	endtask

	// Offer one word until it is taken, log its expectation, then pace the sender.
	task automatic offer_word(input item_t w, input bit typed, input result_t want);
		result_t predicted;
		int gap;
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		dither_and_bin(w, predicted);
		pending_results = {pending_results, (typed ? want : predicted)};
		words_sent++;
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			// One stretch of the run goes with no sender gaps at all.
			if (words_sent >= 250 && words_sent < 330)
				gap = 0;
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Compare one result word field by field.
	task automatic check_result(input result_t got, input result_t want);
		if (got.red_out !== want.red_out) begin
			$error("red_out expected %0d got %0d", want.red_out, got.red_out);
			fail_count++;
		end
		if (got.green_out !== want.green_out) begin
			$error("green_out expected %0d got %0d", want.green_out, got.green_out);
			fail_count++;
		end
		if (got.blue_out !== want.blue_out) begin
			$error("blue_out expected %0d got %0d", want.blue_out, got.blue_out);
			fail_count++;
		end
		if (got.red_count !== want.red_count) begin
			$error("red_count expected %0d got %0d", want.red_count, got.red_count);
			fail_count++;
		end
		if (got.green_count !== want.green_count) begin
			$error("green_count expected %0d got %0d", want.green_count, got.green_count);
			fail_count++;
		end
		if (got.blue_count !== want.blue_count) begin
			$error("blue_count expected %0d got %0d", want.blue_count, got.blue_count);
			fail_count++;
		end
	endtask

	// Result side: every popped word is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("result word arrived with nothing pending");
				fail_count++;
			end else begin
				oldest_expected = pending_results.pop_front();
				check_result(result, oldest_expected);
			end
			results_seen++;
		end
	end

	// Receiver: stretches of different pop patterns, with two long hold-offs.
	initial begin
		int mode;
		int span;
		int k;
		int hold_stage;
		hold_stage = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 60);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= (k % 4 == 0);
					default: pop <= ($urandom_range(0, 9) == 0);
				endcase
			end
			// Hold off long enough for both internal queues to fill and stall the input.
			if ((hold_stage == 0 && results_seen >= 120)
					|| (hold_stage == 1 && results_seen >= 380)) begin
				hold_stage++;
				@(negedge clk);
				pop <= 1'b0;
				repeat (100) @(negedge clk);
			end
		end
	end

	// Directed table, then random words, then drain.
	initial begin
		item_t last;
		item_t w;
		int n;
		arst_n = 1'b0;
		push   = 1'b0;
		item   = '0;
		last   = '0;
		for (n = 0; n < 256; n++) begin
			red_bins[n]   = '0;
			green_bins[n] = '0;
			blue_bins[n]  = '0;
		end
		hot_values[0] = 8'd0;
		hot_values[1] = 8'd255;
		for (n = 2; n < 8; n++)
			hot_values[n] = 8'($urandom_range(0, 255));

		directed = '{
			// Freshly reset bins read as zero, with ignored fields low and high.
			'{read_word(8'd0, 1'b0), 1'b1, uniform_result(8'd0, cnt_t'(0))},
			'{read_word(8'd255, 1'b1), 1'b1, uniform_result(8'd0, cnt_t'(0))},
			// Black at threshold zero stays dark; white at the top threshold goes full.
			'{pixel_word(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'hFF), 1'b1,
				uniform_result(8'd0, cnt_t'(1))},
			'{pixel_word(12'd0, 12'd3, 8'd255, 8'd255, 8'd255, 8'd0), 1'b1,
				uniform_result(8'd255, cnt_t'(1))},
			'{pixel_word(12'hFFC, 12'hFFF, 8'd255, 8'd255, 8'd255, 8'hA5), 1'b1,
				uniform_result(8'd255, cnt_t'(2))},
			'{read_word(8'd255, 1'b0), 1'b1, uniform_result(8'd0, cnt_t'(2))},
			'{read_word(8'd0, 1'b1), 1'b1, uniform_result(8'd0, cnt_t'(1))},
			// Channel values on both sides of several thresholds.
			'{pixel_word(12'hFFF, 12'hFFF, 8'd80, 8'd81, 8'd79, 8'd0), 1'b0, '0},
			'{pixel_word(12'd0, 12'd3, 8'd240, 8'd241, 8'd239, 8'd0), 1'b0, '0},
			'{pixel_word(12'd0, 12'd0, 8'd1, 8'd0, 8'd2, 8'd0), 1'b0, '0},
			'{pixel_word(12'd1, 12'd0, 8'd128, 8'd129, 8'd127, 8'd7), 1'b0, '0},
			'{pixel_word(12'd2, 12'd1, 8'd224, 8'd225, 8'd223, 8'd0), 1'b0, '0},
			'{pixel_word(12'h803, 12'h402, 8'd144, 8'd145, 8'd143, 8'd3), 1'b0, '0},
			// Back-to-back updates of the same bins.
			'{pixel_word(12'h555, 12'hAAA, 8'd176, 8'd177, 8'd175, 8'd0), 1'b0, '0},
			'{pixel_word(12'h555, 12'hAAA, 8'd176, 8'd177, 8'd175, 8'd0), 1'b0, '0},
			'{pixel_word(12'h7FE, 12'h7FD, 8'd0, 8'd255, 8'd0, 8'hFF), 1'b0, '0},
			// Reads of bins touched above.
			'{read_word(8'd80, 1'b1), 1'b0, '0},
			'{read_word(8'd176, 1'b0), 1'b0, '0},
			'{read_word(8'd255, 1'b1), 1'b0, '0},
			'{read_word(8'd0, 1'b0), 1'b0, '0}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		burst_left = $urandom_range(1, 24);

		for (n = 0; n < DIRECTED_ROWS; n++)
			offer_word(directed[n].word, directed[n].typed, directed[n].want);
		for (n = 0; n < RANDOM_WORDS; n++) begin
			make_random_word(last, w);
			offer_word(w, 1'b0, '0);
		end
		push <= 1'b0;

		// Wait for every expected word, then keep the clock running to catch strays.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("ordered_dither_rgb_histogram_top verification clean");
		else
			$display("ordered_dither_rgb_histogram_top verification failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("ordered_dither_rgb_histogram_top verification failed");
		$finish;
	end

endmodule
